>>> sv/cdt_pkg.sv
// Shared types and constants for the countdown timer bank.
// No dependencies; imported by cdt_ctrl, cdt_dp and countdown_timer_bank.
package cdt_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int TIME_BITS  = 24;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
    localparam int PROG_W     = 17;
    localparam int FRAC_BITS  = 16;

    localparam logic [2:0] K_START  = 3'd0;
    localparam logic [2:0] K_STOP   = 3'd1;
    localparam logic [2:0] K_PAUSE  = 3'd2;
    localparam logic [2:0] K_RESUME = 3'd3;
    localparam logic [2:0] K_TICK   = 3'd4;
    localparam logic [2:0] K_QUERY  = 3'd5;
    localparam logic [2:0] K_DRAIN  = 3'd6;
    localparam logic [2:0] K_CLEAR  = 3'd7;

    localparam logic [1:0] RK_STATUS = 2'd0;
    localparam logic [1:0] RK_ENTRY  = 2'd1;
    localparam logic [1:0] RK_NONE   = 2'd2;

    typedef enum logic [1:0] {
        OM_TICK,
        OM_QUERY,
        OM_ENTRY,
        OM_NONE
    } out_mode_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [23:0] duration_ms;
        logic [23:0] elapsed_ms;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0]  reply_kind;
        logic [3:0]  reply_slot;
        logic        exists;
        logic        is_active;
        logic        is_paused;
        logic        has_expired;
        logic [23:0] remaining_ms;
        logic [23:0] total_ms;
        logic [16:0] progress_q16;
        logic [4:0]  expired_now;
        logic        last;
    } rsp_word_t;

    typedef struct packed {
        logic      capture;
        logic      apply;
        logic      tick_step;
        logic      idx_clr;
        logic      idx_inc;
        logic      div_start;
        logic      div_sel_idx;
        logic      load_out;
        out_mode_t out_mode;
    } cdt_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       idx_last;
        logic       cur_expired;
        logic       any_expired;
        logic       entry_last;
        logic       div_busy;
        logic       out_free;
    } cdt_stat_t;

endpackage

>>> sv/cdt_ctrl.sv
// Sequencer for the countdown timer bank: decodes each word and steps the datapath.
// Depends on cdt_pkg.
module cdt_ctrl
    import cdt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cdt_stat_t stat,
    output cdt_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK,
        ST_TICK_OUT,
        ST_QDIV,
        ST_QOUT,
        ST_DSCAN,
        ST_DDIV,
        ST_DOUT,
        ST_DNONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_mode = OM_TICK;
        cmd_ready  = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (stat.kind)
                    K_TICK:
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_TICK;
                    end
                    K_QUERY:
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_QDIV;
                    end
                    K_DRAIN:
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = stat.any_expired ? ST_DSCAN : ST_DNONE;
                    end
                    default:
                    begin
                        cmd.apply  = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_TICK:
            begin
                cmd.tick_step = 1'b1;
                cmd.idx_inc   = 1'b1;
                if (stat.idx_last)
                    state_next = ST_TICK_OUT;
            end
            ST_TICK_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_mode = OM_TICK;
                    state_next   = ST_IDLE;
                end
            end
            ST_QDIV:
            begin
                if (!stat.div_busy)
                    state_next = ST_QOUT;
            end
            ST_QOUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_mode = OM_QUERY;
                    state_next   = ST_IDLE;
                end
            end
            ST_DSCAN:
            begin
                if (stat.cur_expired)
                begin
                    cmd.div_start   = 1'b1;
                    cmd.div_sel_idx = 1'b1;
                    state_next      = ST_DDIV;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_DDIV:
            begin
                if (!stat.div_busy)
                    state_next = ST_DOUT;
            end
            ST_DOUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_mode = OM_ENTRY;
                    cmd.idx_inc  = 1'b1;
                    state_next   = stat.entry_last ? ST_IDLE : ST_DSCAN;
                end
            end
            ST_DNONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_mode = OM_NONE;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> sv/cdt_dp.sv
// Datapath for the countdown timer bank: timer state, tick walk, progress divider
// and the result register. Depends on cdt_pkg.
module cdt_dp
    import cdt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_word_t cmd_word,
    input  cdt_cmd_t  cmd,
    output cdt_stat_t stat,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_word_t rsp_word
);

    cmd_word_t              item_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [3:0]             n_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [NUM_TIMERS-1:0]  exists_reg, active_reg, paused_reg, expired_reg;
    logic [TIME_BITS-1:0]   rem_mem [NUM_TIMERS];
    logic [TIME_BITS-1:0]   tot_mem [NUM_TIMERS];
    logic [IDX_W-1:0]       sel_reg;
    logic                   sel_ok_reg;

    logic                   div_busy_reg, div_special_reg;
    logic [3:0]             div_cnt_reg;
    logic [TIME_BITS-1:0]   div_r_reg;
    logic [PROG_W-1:0]      div_q_reg;

    logic                   rsp_valid_reg;
    rsp_word_t              rsp_reg;
    rsp_word_t              rsp_next;

    logic                   slot_ok;
    logic [IDX_W-1:0]       slot_idx, div_addr, rd_addr;
    logic [TIME_BITS-1:0]   rd_rem, rd_tot, dur, el;
    logic [TIME_BITS:0]     div_r2;
    logic                   div_ge, more;
    logic                   sel_ex;

    assign slot_ok  = (32'(item_reg.slot) < NUM_TIMERS);
    assign slot_idx = IDX_W'(item_reg.slot);
    assign dur      = TIME_BITS'(item_reg.duration_ms);
    assign el       = TIME_BITS'(item_reg.elapsed_ms);
    assign div_addr = cmd.div_sel_idx ? idx_reg : slot_idx;
    assign rd_addr  = cmd.tick_step ? idx_reg : (cmd.div_start ? div_addr : sel_reg);
    assign rd_rem   = rem_mem[rd_addr];
    assign rd_tot   = tot_mem[rd_addr];
    assign div_r2   = {div_r_reg, 1'b0};
    assign div_ge   = (div_r2 >= {1'b0, rd_tot});
    assign sel_ex   = sel_ok_reg && exists_reg[sel_reg];

    // any expired slot above the walk index
    always_comb
    begin
        more = 1'b0;
        for (int j = 0; j < NUM_TIMERS; j++)
        begin
            if (j > 32'(idx_reg) && expired_reg[j])
                more = 1'b1;
        end
    end

    always_comb
    begin
        stat.kind        = item_reg.kind;
        stat.idx_last    = (32'(idx_reg) == NUM_TIMERS - 1);
        stat.cur_expired = expired_reg[idx_reg];
        stat.any_expired = |expired_reg;
        stat.entry_last  = !more || (n_reg == 4'd15);
        stat.div_busy    = div_busy_reg;
        stat.out_free    = !rsp_valid_reg || rsp_ready;
    end

    // item, walk index and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
            idx_reg  <= '0;
            n_reg    <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.capture)
                item_reg <= cmd_word;
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
                n_reg   <= '0;
                cnt_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= stat.idx_last ? '0 : idx_reg + 1'b1;
            end
            if (cmd.load_out && cmd.out_mode == OM_ENTRY)
                n_reg <= n_reg + 4'd1;
            if (cmd.tick_step && active_reg[idx_reg] && !paused_reg[idx_reg]
                && rd_rem <= el)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // per-slot flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exists_reg  <= '0;
            active_reg  <= '0;
            paused_reg  <= '0;
            expired_reg <= '0;
        end
        else
        begin
            if (cmd.apply)
            begin
                case (item_reg.kind)
                    K_START:
                    begin
                        if (slot_ok)
                        begin
                            exists_reg[slot_idx] <= 1'b1;
                            active_reg[slot_idx] <= 1'b1;
                            paused_reg[slot_idx] <= 1'b0;
                        end
                    end
                    K_STOP:
                    begin
                        if (slot_ok && exists_reg[slot_idx])
                            active_reg[slot_idx] <= 1'b0;
                    end
                    K_PAUSE, K_RESUME:
                    begin
                        if (slot_ok && exists_reg[slot_idx] && active_reg[slot_idx])
                            paused_reg[slot_idx] <= (item_reg.kind == K_PAUSE);
                    end
                    K_CLEAR:
                    begin
                        exists_reg  <= '0;
                        active_reg  <= '0;
                        paused_reg  <= '0;
                        expired_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.tick_step && active_reg[idx_reg] && !paused_reg[idx_reg]
                && rd_rem <= el)
            begin
                active_reg[idx_reg]  <= 1'b0;
                expired_reg[idx_reg] <= 1'b1;
            end
            if (cmd.load_out && cmd.out_mode == OM_ENTRY)
                expired_reg[sel_reg] <= 1'b0;
        end
    end

    // time stores; absent slots read as zero through the exists flag
    always_ff @(posedge clk)
    begin
        if (cmd.apply && item_reg.kind == K_START && slot_ok)
        begin
            rem_mem[slot_idx] <= dur;
            tot_mem[slot_idx] <= dur;
        end
        else if (cmd.apply && item_reg.kind == K_STOP && slot_ok && exists_reg[slot_idx])
        begin
            rem_mem[slot_idx] <= '0;
        end
        else if (cmd.tick_step && active_reg[idx_reg] && !paused_reg[idx_reg])
        begin
            rem_mem[idx_reg] <= (rd_rem <= el) ? '0 : rd_rem - el;
        end
    end

    // progress divider: one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg    <= 1'b0;
            div_special_reg <= 1'b0;
            div_cnt_reg     <= '0;
            sel_reg         <= '0;
            sel_ok_reg      <= 1'b0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg    <= 1'b1;
            div_cnt_reg     <= '0;
            sel_reg         <= div_addr;
            sel_ok_reg      <= cmd.div_sel_idx ? 1'b1 : slot_ok;
            div_special_reg <= (rd_tot == '0) || (rd_rem >= rd_tot);
        end
        else if (div_busy_reg)
        begin
            div_cnt_reg <= div_cnt_reg + 4'd1;
            if (div_special_reg || div_cnt_reg == 4'd15)
                div_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            div_r_reg <= rd_rem;
            if (rd_tot == '0)
                div_q_reg <= '0;
            else if (rd_rem >= rd_tot)
                div_q_reg <= PROG_W'(1) << FRAC_BITS;
            else
                div_q_reg <= '0;
        end
        else if (div_busy_reg && !div_special_reg)
        begin
            div_r_reg <= div_ge ? TIME_BITS'(div_r2 - {1'b0, rd_tot}) : TIME_BITS'(div_r2);
            div_q_reg <= {div_q_reg[PROG_W-2:0], div_ge};
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.load_out)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_comb
    begin
        rsp_next = '0;
        case (cmd.out_mode)
            OM_TICK:
            begin
                rsp_next.reply_kind  = RK_STATUS;
                rsp_next.expired_now = 5'(cnt_reg);
                rsp_next.last        = 1'b1;
            end
            OM_QUERY, OM_ENTRY:
            begin
                rsp_next.reply_kind   = (cmd.out_mode == OM_ENTRY) ? RK_ENTRY : RK_STATUS;
                rsp_next.reply_slot   = (cmd.out_mode == OM_ENTRY) ? 4'(sel_reg)
                                                                   : item_reg.slot;
                rsp_next.exists       = sel_ex;
                rsp_next.is_active    = sel_ex && active_reg[sel_reg];
                rsp_next.is_paused    = sel_ex && paused_reg[sel_reg];
                rsp_next.has_expired  = sel_ok_reg && expired_reg[sel_reg];
                rsp_next.remaining_ms = sel_ex ? 24'(rd_rem) : '0;
                rsp_next.total_ms     = sel_ex ? 24'(rd_tot) : '0;
                rsp_next.progress_q16 = sel_ex ? div_q_reg : '0;
                rsp_next.last         = (cmd.out_mode == OM_ENTRY) ? stat.entry_last : 1'b1;
            end
            OM_NONE:
            begin
                rsp_next.reply_kind = RK_NONE;
                rsp_next.last       = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

endmodule

>>> sv/countdown_timer_bank.sv
// Top level of the countdown timer bank: sequencer plus datapath.
// Depends on cdt_pkg, cdt_ctrl and cdt_dp.
//
//   channel | signals                        | payload
//   --------+--------------------------------+------------
//   command | cmd_valid, cmd_ready, cmd_word | cmd_word_t
//   reply   | rsp_valid, rsp_ready, rsp_word | rsp_word_t
//
// One word is handled at a time. Start, stop, pause, resume and clear are applied
// in the state after the word is captured. A tick walks the slots one per cycle.
// A query waits on the shared divider that makes one progress bit a cycle; a drain
// runs the divider for each listed slot and steps past each skipped slot.
// Reset clears every flag at once; the time stores need no clearing pass, since
// a slot that was never started reads through its exists flag as zero.
// The reply register parts the two sides: the next command word is taken while a
// finished reply waits; it holds the sequencer only when a new reply must be loaded.
module countdown_timer_bank
    import cdt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_word_t cmd_word,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_word_t rsp_word
);

    cdt_cmd_t  cmd;
    cdt_stat_t stat;

    // sequencer: decode the word, walk slots, wait on divider and reply slot
    cdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: timer state, divider and reply register
    cdt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_word  (cmd_word),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word)
    );

    // a new reply never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!rsp_valid || rsp_ready))
        else $error("reply overwritten while pending");

    // after a command is taken the sequencer is busy in the next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("command taken while busy");

    // a drain entry always describes an expired, started slot
    a_entry_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_word.reply_kind == RK_ENTRY) |-> (rsp_word.has_expired
        && rsp_word.exists && rsp_word.expired_now == 5'd0))
        else $error("bad drain entry");

    // the nothing-expired reply is always the only and final reply
    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_word.reply_kind == RK_NONE) |-> rsp_word.last)
        else $error("nothing-expired reply not last");

endmodule

>>> verif/countdown_timer_bank_tb.sv
// Self-checking testbench for the countdown timer bank: directed and random command words.
// Depends on cdt_pkg and countdown_timer_bank; the scoreboard class predicts each reply.
module countdown_timer_bank_tb;
    import cdt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 900000;

    int errors = 0;

    // Count a mismatch and print one line about it.
    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    // Timer bank model: holds its own copy of every slot and queues the expected replies.
    class timer_scoreboard;
        bit               started[NUM_TIMERS];
        bit               running[NUM_TIMERS];
        bit               held[NUM_TIMERS];
        bit               fired[NUM_TIMERS];
        logic [23:0]      left_ms[NUM_TIMERS];
        logic [23:0]      loaded_ms[NUM_TIMERS];
        rsp_word_t        pending[$];
        int               replies_seen;
        int               expiries_seen;

        function void wipe();
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                started[i] = 0; running[i] = 0; held[i] = 0; fired[i] = 0;
                left_ms[i] = '0; loaded_ms[i] = '0;
            end
        endfunction

        // Append one expected reply at the tail of the queue.
        function void expect_reply(rsp_word_t r);
            pending = {pending, r};
        endfunction

        function rsp_word_t slot_status(logic [1:0] rk, int idx);
            rsp_word_t r;
            logic [40:0] ratio;
            r = '0;
            r.reply_kind = rk;
            r.reply_slot = idx[3:0];
            if (started[idx])
            begin
                r.exists       = 1'b1;
                r.is_active    = running[idx];
                r.is_paused    = held[idx];
                r.remaining_ms = left_ms[idx];
                r.total_ms     = loaded_ms[idx];
                if (loaded_ms[idx] != 0)
                begin
                    ratio = ({17'd0, left_ms[idx]} << 16) / loaded_ms[idx];
                    r.progress_q16 = (ratio > 41'd65536) ? 17'd65536 : ratio[16:0];
                end
            end
            r.has_expired = fired[idx];
            return r;
        endfunction

        // Note an accepted command word: advance the slots, queue its replies.
        function void note_command(cmd_word_t c);
            rsp_word_t r;
            int        n;
            int        s;
            n = 0;
            s = int'(c.slot);
            case (c.kind)
                K_START:
                begin
                    started[s] = 1; loaded_ms[s] = c.duration_ms;
                    left_ms[s] = c.duration_ms; running[s] = 1; held[s] = 0;
                end
                K_STOP:
                    if (started[s])
                    begin
                        running[s] = 0; left_ms[s] = '0;
                    end
                K_PAUSE, K_RESUME:
                    if (started[s] && running[s])
                        held[s] = (c.kind == K_PAUSE);
                K_TICK:
                begin
                    for (int i = 0; i < NUM_TIMERS; i++)
                    begin
                        if (!running[i] || held[i])
                            continue;
                        if (left_ms[i] <= c.elapsed_ms)
                        begin
                            left_ms[i] = '0; running[i] = 0; fired[i] = 1; n++;
                        end
                        else
                            left_ms[i] -= c.elapsed_ms;
                    end
                    r = '0;
                    r.reply_kind = RK_STATUS;
                    r.expired_now = n[4:0];
                    r.last = 1'b1;
                    expect_reply(r);
                    expiries_seen += n;
                end
                K_QUERY:
                begin
                    r = slot_status(RK_STATUS, s);
                    r.last = 1'b1;
                    expect_reply(r);
                end
                K_DRAIN:
                begin
                    for (int i = 0; i < NUM_TIMERS; i++)
                        if (fired[i])
                        begin
                            expect_reply(slot_status(RK_ENTRY, i));
                            fired[i] = 0;
                            n++;
                        end
                    if (n == 0)
                    begin
                        r = '0;
                        r.reply_kind = RK_NONE;
                        r.last = 1'b1;
                        expect_reply(r);
                    end
                    else
                        pending[$].last = 1'b1;
                end
                default: wipe();
            endcase
        endfunction

        // Compare one accepted reply with the oldest expectation.
        task check_reply(rsp_word_t got);
            rsp_word_t w;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected reply %p", got));
                return;
            end
            w = pending.pop_front();
            replies_seen++;
            if (got.reply_kind !== w.reply_kind || got.reply_slot !== w.reply_slot ||
                got.exists !== w.exists || got.is_active !== w.is_active ||
                got.is_paused !== w.is_paused || got.has_expired !== w.has_expired ||
                got.remaining_ms !== w.remaining_ms || got.total_ms !== w.total_ms ||
                got.progress_q16 !== w.progress_q16 ||
                got.expired_now !== w.expired_now || got.last !== w.last)
                report_mismatch($sformatf("got %p want %p", got, w));
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_ready;
    cmd_word_t cmd_word;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_word_t rsp_word;

    timer_scoreboard board;
    int              cycle_count = 0;
    bit              long_hold = 0;
    int              words_sent = 0;

    countdown_timer_bank DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd_word (cmd_word),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_word (rsp_word)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        board = new();
        board.wipe();
        board.replies_seen = 0;
        board.expiries_seen = 0;
    end

    // Check replies at the edge where they are accepted; predict at command acceptance.
    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && cmd_ready)
            board.note_command(cmd_word);
        if (rst_n && rsp_valid && rsp_ready)
            board.check_reply(rsp_word);
    end

    // Receiver: stall on its own pattern, with calm stretches and one long hold-off.
    initial
    begin
        int mode;
        rsp_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                rsp_ready <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold = 0;
            end
            mode = (cycle_count / 300) % 3;
            if (mode == 0)
                rsp_ready <= 1'b1;
            else if (mode == 1)
                rsp_ready <= ($urandom_range(0, 3) != 0);
            else
                rsp_ready <= ($urandom_range(0, 2) == 0);
        end
    end

    // Cycle limit: end the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offer one word and hold it until accepted.
    task automatic send_word(input cmd_word_t c);
        cmd_valid <= 1'b1;
        cmd_word  <= c;
        do
            @(posedge clk);
        while (!cmd_ready);
        words_sent++;
    endtask

    // Drop valid for a random gap after a burst.
    task automatic idle_gap(input int max_gap);
        int g;
        g = $urandom_range(0, max_gap);
        if (g > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Hold the sender until every expected reply has arrived.
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic cmd_word_t make_word(logic [2:0] k, int s, logic [23:0] d,
                                            logic [23:0] e);
        cmd_word_t c;
        c.kind = k; c.slot = s[3:0]; c.duration_ms = d; c.elapsed_ms = e;
        return c;
    endfunction

    // Random command, mostly start/tick/query with small times so timers expire.
    function automatic cmd_word_t random_word();
        cmd_word_t c;
        int        p;
        c.slot = 4'($urandom_range(0, 15));
        c.duration_ms = ($urandom_range(0, 9) == 0) ? 24'($urandom())
                                                    : 24'($urandom_range(0, 300));
        c.elapsed_ms  = ($urandom_range(0, 9) == 0) ? 24'($urandom())
                                                    : 24'($urandom_range(0, 120));
        p = $urandom_range(0, 99);
        if (p < 28)      c.kind = K_START;
        else if (p < 34) c.kind = K_STOP;
        else if (p < 42) c.kind = K_PAUSE;
        else if (p < 50) c.kind = K_RESUME;
        else if (p < 70) c.kind = K_TICK;
        else if (p < 85) c.kind = K_QUERY;
        else if (p < 98) c.kind = K_DRAIN;
        else             c.kind = K_CLEAR;
        return c;
    endfunction

    initial
    begin
        int burst;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd_word  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty bank, field extremes, zero-time expiry, pause/resume,
        // restart of expired slot, stop on absent slot, progress at full scale.
        send_word(make_word(K_QUERY, 15, '0, '0));
        send_word(make_word(K_DRAIN, 0, '0, '0));
        send_word(make_word(K_STOP, 3, '0, '0));
        send_word(make_word(K_START, 0, 24'hFFFFFF, '0));
        send_word(make_word(K_START, 15, 24'd0, '0));
        send_word(make_word(K_START, 5, 24'd100, '0));
        send_word(make_word(K_START, 6, 24'd3, '0));
        send_word(make_word(K_PAUSE, 5, '0, '0));
        send_word(make_word(K_PAUSE, 9, '0, '0));
        send_word(make_word(K_TICK, 0, '0, 24'd0));
        send_word(make_word(K_QUERY, 0, '0, '0));
        send_word(make_word(K_QUERY, 15, '0, '0));
        send_word(make_word(K_TICK, 0, '0, 24'd3));
        send_word(make_word(K_RESUME, 5, '0, '0));
        send_word(make_word(K_TICK, 0, '0, 24'd40));
        send_word(make_word(K_QUERY, 5, '0, '0));
        send_word(make_word(K_START, 6, 24'd7, '0));
        send_word(make_word(K_STOP, 0, '0, '0));
        send_word(make_word(K_QUERY, 0, '0, '0));
        send_word(make_word(K_DRAIN, 0, '0, '0));
        send_word(make_word(K_TICK, 0, '0, 24'hFFFFFF));
        send_word(make_word(K_DRAIN, 0, '0, '0));
        send_word(make_word(K_CLEAR, 0, '0, '0));
        send_word(make_word(K_QUERY, 6, '0, '0));
        wait_drained();

        // Fill every slot, then query, tick and drain with the receiver held off for a long stretch.
        for (int i = 0; i < NUM_TIMERS; i++)
            send_word(make_word(K_START, i, 24'($urandom_range(0, 50)), '0));
        long_hold = 1;
        for (int i = 0; i < 12; i++)
            send_word(make_word(K_QUERY, i, '0, '0));
        send_word(make_word(K_TICK, 0, '0, 24'd60));
        send_word(make_word(K_DRAIN, 0, '0, '0));
        wait_drained();

        // Random bursts with gaps; pause for a full drain now and then.
        while (words_sent < 270)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst) send_word(random_word());
            if ($urandom_range(0, 9) == 0)
                wait_drained();
            else
                idle_gap(($urandom_range(0, 3) == 0) ? 0 : 15);
        end
        cmd_valid <= 1'b0;
        @(posedge clk);

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.pending.size() != 0)
            report_mismatch($sformatf("%0d replies never arrived", board.pending.size()));

        $display("run covered %0d command words, %0d replies checked, %0d timer expiries",
                 words_sent, board.replies_seen, board.expiries_seen);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
